>>> rtl/sbb_pkg.sv
// package for the separable box blur: sizes, types, states, register indexes
package sbb_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 256;
  localparam int unsigned MAX_HEIGHT_DEF   = 256;
  localparam int unsigned RADIUS_LIMIT_DEF = 64;
  localparam int unsigned CHANNELS         = 4;

  localparam int unsigned RADIUS_W = 7;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
    logic [7:0] in_alpha;
  } sbb_in_t;

  typedef struct packed {
    logic       valid_res;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       last_pixel;
  } sbb_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT,
    ST_ACC,
    ST_DIV,
    ST_WR,
    ST_FETCH,
    ST_OUT
  } sbb_state_t;

endpackage

>>> rtl/sbb_divider.sv
// restoring divider: quotient of a sum by the box span, one bit per cycle
module sbb_divider import sbb_pkg::*; #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  // load on start, otherwise one shift and subtract step while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done longer than one cycle");
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |=> (cnt_r == $past(cnt_r) - 1'b1) || start)
    else $error("divider count skipped");
endmodule

>>> rtl/separable_box_blur_rgba.sv
// top level: image stores, load/fetch control and the blur sequencer
// A load word is taken in the idle state. A fetch word gives its result
// through the FETCH and OUT states and the output register (memory read is registered), and
// input waits until that result is taken. After the last pixel of an image, if the radius
// is not zero, the blur runs before the block is ready again: per output channel value,
// read, wait, add per tap over 2r+1 taps, then divide and write. Reset clears control only.
module separable_box_blur_rgba import sbb_pkg::*; #(
  parameter int unsigned MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = MAX_HEIGHT_DEF,
  parameter int unsigned RADIUS_LIMIT = RADIUS_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sbb_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbb_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned CW_W    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CH_W    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW      = CW_W + 1;
  localparam int unsigned YW      = CH_W + 1;
  localparam int unsigned RL_W    = $clog2(RADIUS_LIMIT + 1);
  localparam int unsigned SPAN_W  = RL_W + 1;
  localparam int unsigned SUM_W   = 8 + SPAN_W;
  localparam int unsigned XI_W    = (XW > YW ? XW : YW) + 1;
  localparam int unsigned KW      = RL_W + 2;

  sbb_state_t state_r, state_nxt;

  logic [RADIUS_W-1:0] radius_r;
  logic [DIM_W-1:0]    width_r, height_r;

  // effective sizes
  logic [RL_W-1:0] r_eff;
  logic [CW_W-1:0] w_eff;
  logic [CH_W-1:0] h_eff;
  logic [CNT_W-1:0] total_eff;

  always_comb begin
    r_eff = (32'(radius_r) > RADIUS_LIMIT) ? RL_W'(RADIUS_LIMIT) : RL_W'(radius_r);
    if (width_r == '0) w_eff = CW_W'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = CW_W'(MAX_WIDTH);
    else w_eff = CW_W'(width_r);
    if (height_r == '0) h_eff = CH_W'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = CH_W'(MAX_HEIGHT);
    else h_eff = CH_W'(height_r);
  end

  // product of the effective sizes, combinational; compared on each load, registered at the last
  assign total_eff = CNT_W'(w_eff) * CNT_W'(h_eff);

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and sequencer registers
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [CNT_W-1:0] fetch_cnt_r, fetch_cnt_nxt;
  logic [CNT_W-1:0] res_total_r, res_total_nxt;
  logic             res_rdy_r, res_rdy_nxt;
  logic             pass_r, pass_nxt;
  logic [XW-1:0]    x_r, x_nxt;
  logic [YW-1:0]    y_r, y_nxt;
  logic [1:0]       ch_r, ch_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CW_W-1:0]  bw_r, bw_nxt;
  logic [CH_W-1:0]  bh_r, bh_nxt;
  logic [RL_W-1:0]  br_r, br_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;
  sbb_out_t         out_r, out_nxt;
  logic             out_v_r, out_v_nxt;

  // memories
  logic [31:0] pix_mem [DEPTH];
  logic [31:0] row_mem [DEPTH];
  logic [31:0] pix_q, row_q;
  logic        pix_we, row_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [31:0] pix_wd, row_wd;

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[wr_addr] <= pix_wd;
    pix_q <= pix_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (row_we) row_mem[wr_addr] <= row_wd;
    row_q <= row_mem[rd_addr];
  end

  // divider
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_q;
  sbb_divider #(.NUM_W(SUM_W), .DEN_W(SPAN_W)) u_div (
    .clk, .rst_n,
    .start(div_start),
    .num(sum_nxt + SUM_W'(br_r)),
    .den(span_r),
    .done(div_done),
    .quot(div_q)
  );

  // neighbor address: clamped x+k-r or y+k-r
  logic signed [XI_W-1:0] nb;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [ADDR_W-1:0] nb_addr, cur_addr;
  always_comb begin
    sx = x_r;
    sy = y_r;
    if (!pass_r) begin
      nb = $signed(XI_W'(x_r)) + $signed(XI_W'(k_r)) - $signed(XI_W'(br_r));
      if (nb < 0) sx = '0;
      else if (nb > $signed(XI_W'(bw_r) - XI_W'(1))) sx = XW'(bw_r) - XW'(1);
      else sx = XW'(nb);
    end else begin
      nb = $signed(XI_W'(y_r)) + $signed(XI_W'(k_r)) - $signed(XI_W'(br_r));
      if (nb < 0) sy = '0;
      else if (nb > $signed(XI_W'(bh_r) - XI_W'(1))) sy = YW'(bh_r) - YW'(1);
      else sy = YW'(nb);
    end
  end
  assign nb_addr  = ADDR_W'(sy * bw_r + sx);
  assign cur_addr = ADDR_W'(y_r * bw_r + x_r);

  logic [31:0] src_word, dst_word;
  logic [7:0]  src_chan;
  assign src_word = pass_r ? row_q : pix_q;
  assign src_chan = src_word[8*ch_r +: 8];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.func == FUNC_FETCH) state_nxt = ST_FETCH;
          else if (CNT_W'(load_cnt_r + 1'b1) >= total_eff && r_eff != '0)
            state_nxt = ST_RD;
        end
      end
      ST_RD:    state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (k_r == KW'({br_r, 1'b0})) ? ST_DIV : ST_RD;
      ST_DIV:   state_nxt = div_done ? ST_WR : ST_DIV;
      ST_WR:    state_nxt = ST_IDLE;
      ST_FETCH: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_WR && !(pass_r && x_r == XW'(bw_r) - XW'(1)
        && ch_r == 2'd3 && y_r == YW'(bh_r) - YW'(1)))
      state_nxt = ST_RD;
  end

  // datapath and outputs
  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    fetch_cnt_nxt = fetch_cnt_r;
    res_total_nxt = res_total_r;
    res_rdy_nxt   = res_rdy_r;
    pass_nxt = pass_r;
    x_nxt = x_r; y_nxt = y_r; ch_nxt = ch_r; k_nxt = k_r; sum_nxt = sum_r;
    bw_nxt = bw_r; bh_nxt = bh_r; br_nxt = br_r; span_nxt = span_r;
    out_nxt = out_r;
    out_v_nxt = out_v_r;
    pix_we = 1'b0; row_we = 1'b0;
    rd_addr = nb_addr;
    wr_addr = cur_addr;
    pix_wd = 32'd0; row_wd = 32'd0;
    div_start = 1'b0;
    dst_word = pass_r ? pix_q : row_q;

    if (out_v_r && out_ready) out_v_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_data.func == FUNC_LOAD) begin
            if (res_rdy_r) begin
              res_rdy_nxt = 1'b0;
              fetch_cnt_nxt = '0;
            end
            pix_we  = 32'(load_cnt_r) < DEPTH;
            wr_addr = ADDR_W'(load_cnt_r);
            pix_wd  = {in_data.in_alpha, in_data.in_red, in_data.in_green,
                       in_data.in_blue};
            load_cnt_nxt = load_cnt_r + 1'b1;
            if (CNT_W'(load_cnt_r + 1'b1) >= total_eff) begin
              res_rdy_nxt   = 1'b1;
              res_total_nxt = total_eff;
              fetch_cnt_nxt = '0;
              load_cnt_nxt  = '0;
              pass_nxt = 1'b0;
              x_nxt = '0; y_nxt = '0; ch_nxt = '0; k_nxt = '0; sum_nxt = '0;
              bw_nxt = w_eff; bh_nxt = h_eff; br_nxt = r_eff;
              span_nxt = SPAN_W'({r_eff, 1'b1});
            end
          end else begin
            rd_addr = ADDR_W'(fetch_cnt_r);
          end
        end
      end
      ST_RD: ;
      ST_WAIT: ;
      ST_ACC: begin
        sum_nxt = sum_r + SUM_W'(src_chan);
        k_nxt = k_r + 1'b1;
        if (k_r == KW'({br_r, 1'b0})) begin
          div_start = 1'b1;
          rd_addr = cur_addr;
        end
      end
      ST_DIV: rd_addr = cur_addr;
      ST_WR: begin
        dst_word[8*ch_r +: 8] = div_q[7:0];
        if (pass_r) begin
          pix_we = 1'b1; pix_wd = dst_word;
        end else begin
          row_we = 1'b1; row_wd = dst_word;
        end
        sum_nxt = '0; k_nxt = '0;
        if (!pass_r) begin
          // row pass: x inner, channel, then row
          if (x_r != XW'(bw_r) - XW'(1)) x_nxt = x_r + 1'b1;
          else begin
            x_nxt = '0;
            if (ch_r != 2'd3) ch_nxt = ch_r + 1'b1;
            else begin
              ch_nxt = '0;
              if (y_r != YW'(bh_r) - YW'(1)) y_nxt = y_r + 1'b1;
              else begin
                y_nxt = '0; pass_nxt = 1'b1;
              end
            end
          end
        end else begin
          // column pass: y inner, channel, then column
          if (y_r != YW'(bh_r) - YW'(1)) y_nxt = y_r + 1'b1;
          else begin
            y_nxt = '0;
            if (ch_r != 2'd3) ch_nxt = ch_r + 1'b1;
            else begin
              ch_nxt = '0;
              x_nxt = x_r + 1'b1;
            end
          end
        end
      end
      ST_FETCH: rd_addr = ADDR_W'(fetch_cnt_r);
      ST_OUT: begin
        out_v_nxt = 1'b1;
        out_nxt = '0;
        if (res_rdy_r && fetch_cnt_r < res_total_r) begin
          out_nxt.valid_res = 1'b1;
          out_nxt.out_blue  = pix_q[7:0];
          out_nxt.out_green = pix_q[15:8];
          out_nxt.out_red   = pix_q[23:16];
          out_nxt.out_alpha = pix_q[31:24];
          fetch_cnt_nxt = fetch_cnt_r + 1'b1;
          if (CNT_W'(fetch_cnt_r + 1'b1) >= res_total_r) begin
            out_nxt.last_pixel = 1'b1;
            res_rdy_nxt = 1'b0;
            fetch_cnt_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // fetch read in idle uses fetch address; hold it during FETCH too
  assign in_ready = (state_r == ST_IDLE) && !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_cnt_r  <= '0;
      fetch_cnt_r <= '0;
      res_total_r <= '0;
      res_rdy_r   <= 1'b0;
      out_v_r     <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      fetch_cnt_r <= fetch_cnt_nxt;
      res_total_r <= res_total_nxt;
      res_rdy_r   <= res_rdy_nxt;
      out_v_r     <= out_v_nxt;
      pass_r      <= pass_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; ch_r <= ch_nxt; k_r <= k_nxt; sum_r <= sum_nxt;
    bw_r <= bw_nxt; bh_r <= bh_nxt; br_r <= br_nxt; span_r <= span_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_v_r) else $error("fetch gave no word");
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.last_pixel) |-> out_r.valid_res)
    else $error("last pixel on empty word");
  a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_rdy_r |-> fetch_cnt_r < res_total_r) else $error("fetch count overrun");
endmodule

>>> test/blur_checker.sv
// checker for the box blur: watches all channels, predicts each fetched word and compares
`timescale 1ns / 100ps
module blur_checker import sbb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sbb_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sbb_out_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam int unsigned DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  // predicted image and horizontal pass
  logic [31:0] image_mem [0:DEPTH-1];
  logic [31:0] row_mem   [0:DEPTH-1];

  logic [RADIUS_W-1:0] radius_reg;
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  int unsigned         load_cnt;
  int unsigned         fetch_cnt;
  int unsigned         pixel_total;
  bit                  have_image;
  sbb_out_t            expected_px [$];

  function automatic int unsigned clip_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // clamped box sum, rows first, then columns
  task automatic blur_image(int w, int h, int r);
    int sum;
    int pos;
    int span;
    span = 2 * r + 1;
    if (r == 0) return;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sum = 0;
          for (int k = -r; k <= r; k++) begin
            pos = x + k;
            if (pos < 0) pos = 0;
            if (pos > w - 1) pos = w - 1;
            sum += image_mem[y * w + pos][8 * c +: 8];
          end
          row_mem[y * w + x][8 * c +: 8] = 8'((sum + r) / span);
        end
      end
    end
    for (int x = 0; x < w; x++) begin
      for (int y = 0; y < h; y++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sum = 0;
          for (int k = -r; k <= r; k++) begin
            pos = y + k;
            if (pos < 0) pos = 0;
            if (pos > h - 1) pos = h - 1;
            sum += row_mem[pos * w + x][8 * c +: 8];
          end
          image_mem[y * w + x][8 * c +: 8] = 8'((sum + r) / span);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    int unsigned w;
    int unsigned h;
    int unsigned r;
    logic [31:0] word;
    sbb_out_t    want;
    if (!rst_n) begin
      radius_reg  = '0;
      width_reg   = DIM_W'(1);
      height_reg  = DIM_W'(1);
      load_cnt    = 0;
      fetch_cnt   = 0;
      pixel_total = 0;
      have_image  = 0;
      errors      = 0;
      expected_px.delete();
    end else begin
      // result word check
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
        end else begin
          want = expected_px.pop_front();
          if (out_data !== want) begin
            errors++;
            $display("%0t: mismatch expected v=%0d b=%h g=%h r=%h a=%h last=%0d", $time,
                     want.valid_res, want.out_blue, want.out_green, want.out_red,
                     want.out_alpha, want.last_pixel);
            $display("%0t:          actual v=%0d b=%h g=%h r=%h a=%h last=%0d", $time,
                     out_data.valid_res, out_data.out_blue, out_data.out_green,
                     out_data.out_red, out_data.out_alpha, out_data.last_pixel);
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS: radius_reg = cfg_data[RADIUS_W-1:0];
          REG_WIDTH:  width_reg  = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      // input word: load or fetch
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_LOAD) begin
          w = clip_dim(width_reg, MAX_WIDTH_DEF);
          h = clip_dim(height_reg, MAX_HEIGHT_DEF);
          r = (radius_reg > RADIUS_LIMIT_DEF) ? RADIUS_LIMIT_DEF : radius_reg;
          if (have_image) begin
            have_image = 0;
            fetch_cnt  = 0;
          end
          if (load_cnt < DEPTH)
            image_mem[load_cnt] = {in_data.in_alpha, in_data.in_red,
                                   in_data.in_green, in_data.in_blue};
          load_cnt = (load_cnt + 1) & 17'h1FFFF;
          if (load_cnt >= w * h) begin
            blur_image(w, h, r);
            have_image  = 1;
            pixel_total = w * h;
            fetch_cnt   = 0;
            load_cnt    = 0;
          end
        end else begin
          want = '0;
          if (have_image && fetch_cnt < pixel_total) begin
            word = image_mem[fetch_cnt];
            want.valid_res = 1'b1;
            want.out_blue  = word[7:0];
            want.out_green = word[15:8];
            want.out_red   = word[23:16];
            want.out_alpha = word[31:24];
            fetch_cnt++;
            if (fetch_cnt >= pixel_total) begin
              want.last_pixel = 1'b1;
              have_image = 0;
              fetch_cnt  = 0;
            end
          end
          expected_px.push_back(want);
        end
      end
    end
    pending = expected_px.size();
  end

endmodule

>>> test/testbench.sv
// testbench top for the box blur: stimulus, handshake pressure and verdict
`timescale 1ns / 100ps
module testbench;
  import sbb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 50000000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sbb_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sbb_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;

  int unsigned cycles = 0;
  int unsigned items = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  bit          loads_sent = 0;
  int unsigned radius_now = 0;
  int unsigned width_now = 1;
  int unsigned height_now = 1;

  separable_box_blur_rgba dut (.*);
  blur_checker checker_i (.*);

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("separable_box_blur_rgba regression: fail");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int unsigned eff_dim(int unsigned v);
    v &= 9'h1FF;
    if (v == 0) return 1;
    return (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
  endfunction

  // one input word; valid stays up between back-to-back words
  task automatic send_word(logic f, logic [31:0] px);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, in_blue: px[7:0], in_green: px[15:8],
                  in_red: px[23:16], in_alpha: px[31:24]};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items++;
    if (f == FUNC_LOAD) loads_sent = 1;
  endtask

  // wait for every fetched word, then for a possible blur to finish
  task automatic drain();
    int unsigned r;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    if (loads_sent) begin
      r = (radius_now & 7'h7F) > RADIUS_LIMIT_DEF ? RADIUS_LIMIT_DEF : (radius_now & 7'h7F);
      repeat (8 * eff_dim(width_now) * eff_dim(height_now) * (6 * r + 21) + 40)
        @(posedge clk);
    end else begin
      repeat (20) @(posedge clk);
    end
    loads_sent = 0;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RADIUS: radius_now = val[RADIUS_W-1:0];
      REG_WIDTH:  width_now  = val;
      REG_HEIGHT: height_now = val;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic loads(int unsigned n);
    repeat (n) send_word(FUNC_LOAD, rand_pixel());
  endtask

  task automatic fetches(int unsigned n);
    repeat (n) send_word(FUNC_FETCH, $urandom);
  endtask

  task automatic set_all(int unsigned r, int unsigned w, int unsigned h);
    cfg_write(REG_RADIUS, CFG_DATA_W'(r));
    cfg_write(REG_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  initial begin
    int unsigned n;
    int unsigned part;
    int unsigned w;
    int unsigned h;
    bit          held;
    held = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fetch with nothing pending, then reset sizes with full-scale pixels
    fetches(1);
    send_word(FUNC_LOAD, 32'hFFFF_FFFF);
    fetches(1);
    send_word(FUNC_LOAD, 32'h0);
    fetches(2);
    drain();
    // radius above limit, zero width
    set_all(127, 0, 3);
    loads(3);
    fetches(4);
    drain();
    // width above max, upper radius bits ignored, unused register index
    set_all(9'h180, 511, 1);
    cfg_write(REG_SPARE, 9'h1FF);
    loads(256);
    fetches(256);
    drain();
    set_all(64, 2, 2);
    loads(4);
    fetches(4);
    drain();
    set_all(1, 1, 256);
    loads(256);
    fetches(256);
    drain();
    // size shrunk during loading
    set_all(1, 4, 4);
    loads(6);
    drain();
    cfg_write(REG_WIDTH, 9'd2);
    cfg_write(REG_HEIGHT, 9'd2);
    loads(1);
    fetches(4);
    drain();
    // config change after blurring
    set_all(2, 3, 2);
    loads(6);
    drain();
    set_all(0, 1, 1);
    fetches(7);
    drain();
    // load while results pending
    set_all(1, 2, 2);
    loads(4);
    fetches(2);
    loads(4);
    fetches(4);
    drain();

    // random images
    while (items < 1950) begin
      if (items > 1750) quiet = 1;
      drain();
      if (!held) begin
        w = 8;
        h = 8;
        set_all($urandom_range(0, 3), w, h);
      end else begin
        w = $urandom_range(0, 9);
        h = $urandom_range(0, 9);
        if ($urandom_range(0, 39) == 0) begin
          w = $urandom_range(200, 511);
          h = $urandom_range(0, 1);
        end
        if ($urandom_range(0, 2) != 0) cfg_write(REG_WIDTH, CFG_DATA_W'(w));
        if ($urandom_range(0, 2) != 0) cfg_write(REG_HEIGHT, CFG_DATA_W'(h));
        if ($urandom_range(0, 2) != 0)
          cfg_write(REG_RADIUS, CFG_DATA_W'(($urandom_range(0, 9) == 0)
                                            ? $urandom_range(0, 511)
                                            : $urandom_range(0, 4)));
      end
      n = eff_dim(width_now) * eff_dim(height_now);
      if ($urandom_range(0, 5) == 0) fetches(1);
      if (n > 2 && $urandom_range(0, 7) == 0) begin
        part = $urandom_range(1, n - 1);
        loads(part);
        fetches($urandom_range(1, 2));
        loads(n - part);
      end else begin
        loads(n);
      end
      if (!held) begin
        hold_req = 1;
        held = 1;
        fetches(n);
      end else if (n > 1 && $urandom_range(0, 7) == 0) begin
        fetches($urandom_range(1, n - 1));
        loads(n);
        fetches(n);
      end else begin
        fetches(n + $urandom_range(0, 2));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("separable_box_blur_rgba regression: pass");
    end else begin
      $display("separable_box_blur_rgba regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sbb_pkg.sv
rtl/sbb_divider.sv
rtl/separable_box_blur_rgba.sv
test/blur_checker.sv
test/testbench.sv
